// File: hdl/otq_pkg.sv
// otq_pkg: shared types, constants and helpers of the ordered timer queue
// used by every file of the block; depends on nothing

package otq_pkg;

  localparam int TIME_W = 31;
  localparam int ID_W = 4;
  localparam int OP_W = 2;
  localparam int PEND_W = 5;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [ID_W-1:0] id_t;
  typedef logic [OP_W-1:0] op_t;
  typedef logic [PEND_W-1:0] pend_t;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_CANCEL = 2'd1;
  localparam op_t OP_RUN = 2'd2;

  localparam time_t TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_REMOVE,
    CMD_POP,
    CMD_INSERT
  } cmd_e;

  typedef struct packed {
    logic  valid;
    id_t   id;
    time_t deadline;
    time_t period;
  } entry_t;

  typedef struct packed {
    cmd_e  op;
    id_t   id;
    time_t deadline;
    time_t period;
  } cmd_t;

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

// File: hdl/otq_if.sv
// otq_req_if and otq_res_if: valid/ready channels of the timer queue
// depends on otq_pkg

interface otq_req_if;
  logic                valid;
  logic                ready;
  otq_pkg::op_t        op;
  otq_pkg::id_t        task_id;
  otq_pkg::time_t      now;
  otq_pkg::time_t      delay;
  otq_pkg::time_t      period;

  modport source (output valid, op, task_id, now, delay, period, input ready);
  modport sink (input valid, op, task_id, now, delay, period, output ready);
endinterface

interface otq_res_if;
  logic                valid;
  logic                ready;
  logic                fired_valid;
  otq_pkg::id_t        fired_id;
  logic                last;
  otq_pkg::pend_t      pending_count;

  modport source (output valid, fired_valid, fired_id, last, pending_count, input ready);
  modport sink (input valid, fired_valid, fired_id, last, pending_count, output ready);
endinterface

// File: hdl/otq_cell.sv
// otq_cell: one slot of the sorted timer chain, shifts with its neighbors
// depends on otq_pkg

module otq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  otq_pkg::cmd_t   cmd_i,
  input  otq_pkg::entry_t left_i,
  input  otq_pkg::entry_t right_i,
  input  logic            lt_prev_i,
  input  logic            shift_prev_i,
  output logic            lt_o,
  output logic            shift_o,
  output otq_pkg::entry_t ent_o
);
  import otq_pkg::*;

  entry_t ent_q, ent_d;
  logic   match;

  assign match = ent_q.valid && (ent_q.id == cmd_i.id) && (cmd_i.op == CMD_REMOVE);
  assign shift_o = ((cmd_i.op == CMD_REMOVE) || (cmd_i.op == CMD_POP)) &&
                   (shift_prev_i || match);
  assign lt_o = ent_q.valid && (ent_q.deadline < cmd_i.deadline);

  always_comb begin
    ent_d = ent_q;
    case (cmd_i.op)
      CMD_REMOVE, CMD_POP: begin
        if (shift_o) ent_d = right_i;
      end
      CMD_INSERT: begin
        if (!lt_o) begin
          if (lt_prev_i) begin
            ent_d.valid = 1'b1;
            ent_d.id = cmd_i.id;
            ent_d.deadline = cmd_i.deadline;
            ent_d.period = cmd_i.period;
          end else begin
            ent_d = left_i;
          end
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// File: hdl/otq_fire_log.sv
// otq_fire_log: memory of the task ids fired during one run
// depends on otq_pkg

module otq_fire_log #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  otq_pkg::id_t  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output otq_pkg::id_t  rdata_o
);
  import otq_pkg::*;

  id_t mem [DEPTH];
  id_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ordered_timer_queue_top.sv
// ordered_timer_queue_top: deadline-ordered timer queue built as a chain of cells
// depends on otq_pkg, otq_if, otq_cell and otq_fire_log
//
// req_i takes one request per handshake: add (op 0), cancel (op 1) or run (op 2).
// res_o returns one result per firing of a run, or a single non-fire result
// for anything else; last marks the final result of a request and
// pending_count gives the queue size after the whole request.
// Steps of each request, with a free receiver:
//   add runs a remove pass, an insert pass and the output load;
//   cancel a remove pass and the output load, an unused op the output load alone.
//   a run pops each ripe head, and re-inserts a periodic one through the chain,
//   then checks once more and finds the head not ripe or the cap hit,
//   then reads the fire log and loads the output register for each result;
//   a run that fires nothing loads its result straight after that check.
// The rate is set by the single command broadcast to the cell chain each
// cycle and by the one read port of the fire log.
// Requests are taken only between commands; the next request is accepted
// while the last result of the previous one still sits in the output register.
// A stalled receiver holds the result and stops the block before the next load.
// Reset empties the chain at once (valid bits clear) and drops any result.

module ordered_timer_queue_top #(
  parameter int SLOTS = 16,
  parameter int MAX_FIRES = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  otq_req_if.sink   req_i,
  otq_res_if.source res_o
);
  import otq_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int NF_W = $clog2(MAX_FIRES + 1);
  localparam int LOG_AW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_RUN,
    S_REINS,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [NF_W-1:0]   nf_q;
  logic [LOG_AW-1:0] rd_idx_q;
  op_t               op_q;
  id_t               id_q;
  time_t             now_q;
  time_t             dl_q;
  time_t             per_q;
  logic              out_valid_q;
  logic              out_fired_q;
  id_t               out_id_q;
  logic              out_last_q;
  pend_t             out_pend_q;

  entry_t ent [SLOTS];
  logic   lt_w [SLOTS];
  logic   shift_w [SLOTS];
  cmd_t   cmd;
  entry_t head;
  logic   ripe;
  logic   full;
  logic   out_free;
  logic   is_last;
  logic [NF_W-1:0] rd_next;
  id_t    log_rdata;

  assign head = ent[0];
  assign full = (count_q == CNT_W'(SLOTS));
  assign ripe = (nf_q < NF_W'(MAX_FIRES)) && head.valid && (now_q >= head.deadline);
  assign out_free = !out_valid_q || res_o.ready;
  assign rd_next = NF_W'(rd_idx_q) + NF_W'(1);
  assign is_last = (nf_q == '0) || (rd_next == nf_q);

  always_comb begin
    cmd.op = CMD_IDLE;
    cmd.id = id_q;
    cmd.deadline = dl_q;
    cmd.period = per_q;
    case (state_q)
      S_REMOVE: cmd.op = CMD_REMOVE;
      S_INSERT: if (!full) cmd.op = CMD_INSERT;
      S_RUN:    if (ripe) cmd.op = CMD_POP;
      S_REINS:  cmd.op = CMD_INSERT;
      default:  cmd.op = CMD_IDLE;
    endcase
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t left_w, right_w;
    logic   lt_prev_w, shift_prev_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
      assign lt_prev_w = 1'b1;
      assign shift_prev_w = (cmd.op == CMD_POP);
    end else begin : g_mid
      assign left_w = ent[k-1];
      assign lt_prev_w = lt_w[k-1];
      assign shift_prev_w = shift_w[k-1];
    end
    if (k == SLOTS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = ent[k+1];
    end
    otq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_w),
      .right_i     (right_w),
      .lt_prev_i   (lt_prev_w),
      .shift_prev_i(shift_prev_w),
      .lt_o        (lt_w[k]),
      .shift_o     (shift_w[k]),
      .ent_o       (ent[k])
    );
  end

  otq_fire_log #(
    .DEPTH(MAX_FIRES),
    .AW   (LOG_AW)
  ) u_fire_log (
    .clk_i  (clk_i),
    .we_i   ((state_q == S_RUN) && ripe),
    .waddr_i(nf_q[LOG_AW-1:0]),
    .wdata_i(head.id),
    .raddr_i(rd_idx_q),
    .rdata_o(log_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      nf_q <= '0;
      rd_idx_q <= '0;
      op_q <= OP_ADD;
      id_q <= '0;
      now_q <= '0;
      dl_q <= '0;
      per_q <= '0;
      out_valid_q <= 1'b0;
      out_fired_q <= 1'b0;
      out_id_q <= '0;
      out_last_q <= 1'b0;
      out_pend_q <= '0;
    end else begin
      if (out_valid_q && res_o.ready && (state_q != S_EMIT_WR)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q <= req_i.op;
            id_q <= req_i.task_id;
            now_q <= req_i.now;
            dl_q <= sat_add(req_i.now, req_i.delay);
            per_q <= req_i.period;
            nf_q <= '0;
            rd_idx_q <= '0;
            if ((req_i.op == OP_ADD) || (req_i.op == OP_CANCEL)) begin
              state_q <= S_REMOVE;
            end else if (req_i.op == OP_RUN) begin
              state_q <= S_RUN;
            end else begin
              state_q <= S_EMIT_WR;
            end
          end
        end
        S_REMOVE: begin
          if (shift_w[SLOTS-1]) count_q <= count_q - CNT_W'(1);
          state_q <= (op_q == OP_ADD) ? S_INSERT : S_EMIT_WR;
        end
        S_INSERT: begin
          if (!full) count_q <= count_q + CNT_W'(1);
          state_q <= S_EMIT_WR;
        end
        S_RUN: begin
          if (ripe) begin
            count_q <= count_q - CNT_W'(1);
            nf_q <= nf_q + NF_W'(1);
            id_q <= head.id;
            dl_q <= sat_add(head.deadline, head.period);
            per_q <= head.period;
            if (head.period != '0) state_q <= S_REINS;
          end else begin
            state_q <= (nf_q == '0) ? S_EMIT_WR : S_EMIT_RD;
          end
        end
        S_REINS: begin
          count_q <= count_q + CNT_W'(1);
          state_q <= S_RUN;
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_fired_q <= (nf_q != '0);
            out_id_q <= (nf_q != '0) ? log_rdata : '0;
            out_last_q <= is_last;
            out_pend_q <= PEND_W'(count_q);
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              rd_idx_q <= rd_next[LOG_AW-1:0];
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.fired_valid = out_fired_q;
  assign res_o.fired_id = out_id_q;
  assign res_o.last = out_last_q;
  assign res_o.pending_count = out_pend_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("queue count above slot count");

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) == head.valid)
    else $error("head valid bit disagrees with queue count");

  a_reins_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REINS) |-> ($past(state_q) == S_RUN) && (per_q != '0))
    else $error("re-insert without a periodic pop");

  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NF_W'(MAX_FIRES))
    else $error("firing count above cap");

  a_fired_only_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_WR) && out_free && (nf_q != '0) |-> (op_q == OP_RUN))
    else $error("fired result outside a run");
`endif

endmodule

// File: dv/ordered_timer_queue_top_tb.sv
// ordered_timer_queue_top_tb: add, cancel, run and unused-op requests against a local
// deadline-ordered queue model, every result checked in order
// depends on otq_pkg, otq_if and ordered_timer_queue_top

module ordered_timer_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import otq_pkg::*;

  localparam int SLOTS = 16;
  localparam int MAX_FIRES = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    logic  fired_valid;
    id_t   fired_id;
    logic  last;
    pend_t pending_count;
  } timer_result_t;

  logic clk_i;
  logic rst_ni;

  otq_req_if req_bus ();
  otq_res_if res_bus ();

  ordered_timer_queue_top #(
    .SLOTS(SLOTS),
    .MAX_FIRES(MAX_FIRES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(req_bus),
    .res_o(res_bus)
  );

  // local copy of the timer queue, head at index 0
  id_t   slot_id[SLOTS];
  time_t slot_deadline[SLOTS];
  time_t slot_period[SLOTS];
  int    queued = 0;

  timer_result_t expected_results[$];

  int    send_idle_pct = 38;
  int    recv_idle_pct = 79;
  int    hold_off_left = 0;
  int    cycle_count = 0;
  int    mismatch_count = 0;
  int    results_seen = 0;
  int    firings_seen = 0;
  int    requests_by_op[4] = '{0, 0, 0, 0};
  time_t timeline_ms = 31'd5000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic time_t clamp_sum(time_t a, time_t b);
    logic [31:0] total;
    total = 32'(a) + 32'(b);
    return (total > 32'(TIME_MAX)) ? TIME_MAX : time_t'(total);
  endfunction

  function automatic void drop_slot(int pos);
    for (int k = pos; k < queued - 1; k++) begin
      slot_id[k] = slot_id[k+1];
      slot_deadline[k] = slot_deadline[k+1];
      slot_period[k] = slot_period[k+1];
    end
    queued--;
  endfunction

  function automatic void drop_task(id_t id);
    for (int k = 0; k < queued; k++) begin
      if (slot_id[k] == id) begin
        drop_slot(k);
        return;
      end
    end
  endfunction

  // equal deadlines: the newcomer goes ahead
  function automatic void file_task(id_t id, time_t deadline, time_t period);
    int pos;
    pos = 0;
    if (queued >= SLOTS) return;
    while (pos < queued && slot_deadline[pos] < deadline) pos++;
    for (int k = queued; k > pos; k--) begin
      slot_id[k] = slot_id[k-1];
      slot_deadline[k] = slot_deadline[k-1];
      slot_period[k] = slot_period[k-1];
    end
    slot_id[pos] = id;
    slot_deadline[pos] = deadline;
    slot_period[pos] = period;
    queued++;
  endfunction

  function automatic void predict_timer_results(op_t op, id_t id, time_t now,
                                                time_t delay, time_t period);
    id_t           fired[$];
    id_t           head_id;
    time_t         head_deadline;
    time_t         head_period;
    timer_result_t res;
    requests_by_op[op]++;
    case (op)
      OP_ADD: begin
        drop_task(id);
        file_task(id, clamp_sum(now, delay), period);
      end
      OP_CANCEL: drop_task(id);
      OP_RUN: begin
        while (fired.size() < MAX_FIRES && queued > 0 && now >= slot_deadline[0]) begin
          head_id = slot_id[0];
          head_deadline = slot_deadline[0];
          head_period = slot_period[0];
          drop_slot(0);
          fired.push_back(head_id);
          if (head_period != '0) file_task(head_id, clamp_sum(head_deadline, head_period),
                                           head_period);
        end
      end
      default: ;
    endcase
    if (fired.size() == 0) begin
      res = '{1'b0, id_t'(0), 1'b1, pend_t'(queued)};
      expected_results.push_back(res);
    end else begin
      foreach (fired[k]) begin
        res = '{1'b1, fired[k], k == fired.size() - 1, pend_t'(queued)};
        expected_results.push_back(res);
      end
    end
  endfunction

  function automatic void flag_mismatch(string what, timer_result_t want, timer_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected fired_valid=%0b fired_id=%0d last=%0b pending=%0d, got fired_valid=%0b fired_id=%0d last=%0b pending=%0d",
               $realtime, what, want.fired_valid, want.fired_id, want.last,
               want.pending_count, got.fired_valid, got.fired_id, got.last,
               got.pending_count);
  endfunction

  always @(posedge clk_i) begin : check_results
    timer_result_t got;
    timer_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.fired_valid, res_bus.fired_id, res_bus.last, res_bus.pending_count};
      results_seen++;
      if (got.fired_valid === 1'b1) firings_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no request waiting", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.fired_valid !== want.fired_valid || got.fired_id !== want.fired_id ||
            got.last !== want.last || got.pending_count !== want.pending_count)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : result_receiver
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(op_t op, id_t id, time_t now, time_t delay, time_t period);
    int gaps;
    gaps = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.task_id <= id;
    req_bus.now <= now;
    req_bus.delay <= delay;
    req_bus.period <= period;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    predict_timer_results(op, id, now, delay, period);
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic send_random_request();
    op_t   op;
    id_t   id;
    time_t now;
    time_t delay;
    time_t period;
    int    roll;
    roll = $urandom_range(99);
    op = roll < 45 ? OP_ADD : roll < 60 ? OP_CANCEL : roll < 97 ? OP_RUN : OP_UNUSED;
    id = id_t'($urandom_range(15));
    if ($urandom_range(19) == 0) begin
      // full-range values
      now = time_t'($urandom());
      delay = time_t'($urandom());
      period = $urandom_range(1) ? time_t'($urandom()) : '0;
    end else begin
      if (op == OP_RUN) timeline_ms += time_t'($urandom_range(150));
      now = timeline_ms;
      delay = time_t'($urandom_range(300));
      case ($urandom_range(3))
        0, 1: period = '0;
        2: period = time_t'($urandom_range(120, 20));
        default: period = time_t'($urandom_range(8, 1));
      endcase
    end
    send_request(op, id, now, delay, period);
  endtask

  task automatic test_empty_queue();
    send_request(OP_RUN, id_t'(0), '0, '0, '0);
    send_request(OP_CANCEL, id_t'(9), time_t'(100), '0, '0);
    send_request(OP_UNUSED, id_t'(6), TIME_MAX, TIME_MAX, TIME_MAX);
    drain_results();
  endtask

  // fill every slot with grouped equal deadlines, re-add and cancel, then
  // fire with a one-ms periodic entry catching up to the firing cap
  task automatic test_full_queue_order();
    for (int i = 0; i < SLOTS; i++)
      send_request(OP_ADD, id_t'(i), time_t'(1000), time_t'((i % 4) * 10),
                   (i == 3) ? time_t'(1) : time_t'(0));
    send_request(OP_ADD, id_t'(7), time_t'(1000), time_t'(5), '0);
    send_request(OP_CANCEL, id_t'(12), '0, '0, '0);
    send_request(OP_CANCEL, id_t'(12), '0, '0, '0);
    send_request(OP_RUN, '0, time_t'(1100), '0, '0);
    send_request(OP_CANCEL, id_t'(3), '0, '0, '0);
    drain_results();
  endtask

  task automatic test_deadline_saturation();
    send_request(OP_ADD, id_t'(15), TIME_MAX, TIME_MAX, TIME_MAX);
    send_request(OP_RUN, id_t'(15), TIME_MAX, '0, '0);
    send_request(OP_CANCEL, id_t'(15), '0, '0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(int sender_idle, int receiver_idle, int count);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (count) send_random_request();
    drain_results();
  endtask

  task automatic test_receiver_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 300;
    repeat (30) send_random_request();
    drain_results();
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.op <= OP_ADD;
    req_bus.task_id <= '0;
    req_bus.now <= '0;
    req_bus.delay <= '0;
    req_bus.period <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_full_queue_order();
    test_deadline_saturation();
    test_random_traffic(38, 79, 110);
    test_random_traffic(79, 38, 110);
    test_random_traffic(0, 0, 110);
    test_receiver_hold_off();

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end
    $display("requests: %0d add, %0d cancel, %0d run, %0d unused op",
             requests_by_op[OP_ADD], requests_by_op[OP_CANCEL], requests_by_op[OP_RUN],
             requests_by_op[OP_UNUSED]);
    $display("results checked: %0d, of which %0d firings; mismatches: %0d",
             results_seen, firings_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
